// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the sequencer design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MSPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MSPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msps_pkg.sv =====
// ---------------------------------------------------------------------------
// msps_pkg
// Shared constants, codes and coil tables of the stepper position sequencer.
// ---------------------------------------------------------------------------
package msps_pkg;

    localparam int PAW_MOTORS_DEF    = 5;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 1;
    localparam int VALUE_BITS     = 16;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_ANGLE = 2'd1;
    localparam logic [1:0] KIND_PAW   = 2'd2;

    // paw actions
    localparam logic [1:0] ACT_UP   = 2'd0;
    localparam logic [1:0] ACT_DOWN = 2'd1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UP_POSITION   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DOWN_POSITION = 1'b1;

    // angle limit in degrees
    localparam logic signed [VALUE_BITS-1:0] ANGLE_LIMIT = 16'sd180;

    // (1138*a +- 50)/100 folded into one multiply: 1138*335545 and 50*335545,
    // then >> 25 (335545 / 2^25 ~ 1/100, exact for sums below 2^25/68)
    localparam logic [31:0] SCALE_MUL   = 32'd381850210;
    localparam logic [31:0] SCALE_OFS   = 32'd16777250;
    localparam int          SCALE_SHIFT = 25;
    localparam int          PROD_BITS   = 40;
    localparam int          STEPS_BITS  = 12;

    typedef struct packed {
        logic step;
        logic load;
    } t_lane_ctl;

    // half-step table of the 4-coil motor
    function automatic logic [3:0] top_coil_lut(input logic [2:0] phase);
        logic [3:0] coils;
        case (phase)
            3'd0:    coils = 4'h9;
            3'd1:    coils = 4'h1;
            3'd2:    coils = 4'h3;
            3'd3:    coils = 4'h2;
            3'd4:    coils = 4'h6;
            3'd5:    coils = 4'h4;
            3'd6:    coils = 4'hc;
            3'd7:    coils = 4'h8;
            default: coils = 4'h0;
        endcase
        return coils;
    endfunction

    // {IN1, IN2} of a 2-coil motor
    function automatic logic [1:0] paw_coil_lut(input logic [1:0] phase);
        logic [1:0] coils;
        case (phase)
            2'd0:    coils = 2'h3;
            2'd1:    coils = 2'h2;
            2'd2:    coils = 2'h0;
            2'd3:    coils = 2'h1;
            default: coils = 2'h0;
        endcase
        return coils;
    endfunction

endpackage

// ===== design/msps_ifs.sv =====
// ---------------------------------------------------------------------------
// msps channel interfaces
// Command item channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
interface msps_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic              key_level;
    logic signed [15:0] angle;
    logic [2:0]        motor_index;
    logic [1:0]        paw_action;

    modport source (output valid, kind, key_level, angle, motor_index, paw_action,
                    input ready);
    modport sink   (input valid, kind, key_level, angle, motor_index, paw_action,
                    output ready);
endinterface

interface msps_result_if
    import msps_pkg::*;
#(
    parameter int PAW_MOTORS = PAW_MOTORS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [3:0]              top_coils;
    logic [2*PAW_MOTORS-1:0] paw_coils;
    logic [PAW_MOTORS-1:0]   paw_enables;
    logic [PAW_MOTORS:0]     moving;
    logic                    angle_rejected;

    modport source (output valid, top_coils, paw_coils, paw_enables, moving,
                    angle_rejected, input ready);
    modport sink   (input valid, top_coils, paw_coils, paw_enables, moving,
                    angle_rejected, output ready);
endinterface

interface msps_cfg_if
    import msps_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic signed [VALUE_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/multi_stepper_position_sequencer.sv =====
// ---------------------------------------------------------------------------
// multi_stepper_position_sequencer
// Half-step sequencer for one 4-coil top stepper and a row of 2-coil paw
// steppers, driven by timer ticks and position commands.
// ---------------------------------------------------------------------------
//  channel    dir  signals                                    handshake
//  i_item     in   kind key_level angle motor_index paw_action valid/ready
//  o_result   out  top_coils paw_coils paw_enables moving ... valid/ready
//  i_cfg      in   index data                                 valid/ready
//
//  One item per cycle while the result is not stalled; a taken item passes
//  the input register, then the result register.
//  All motors, the key press detection and the angle scaling update together.
//  i_rst_n is synchronous; reset puts every motor at position 0, stopped.
//  A stalled result holds the result register; one more item waits in the
//  input register before i_item.ready drops. i_cfg.ready is always high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_stepper_position_sequencer
    import msps_pkg::*;
#(
    parameter int PAW_MOTORS    = PAW_MOTORS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    msps_item_if.sink      i_item,
    msps_result_if.source  o_result,
    msps_cfg_if.sink       i_cfg
);

    // configuration
    logic signed [VALUE_BITS-1:0] r_up_position;
    logic signed [VALUE_BITS-1:0] r_down_position;

    // input register
    logic                         r_in_valid;
    logic [1:0]                   r_in_kind;
    logic                         r_in_key;
    logic signed [VALUE_BITS-1:0] r_in_angle;
    logic [2:0]                   r_in_motor;
    logic [1:0]                   r_in_action;

    // result register
    logic                    r_out_valid;
    logic [3:0]              r_out_top_coils;
    logic [2*PAW_MOTORS-1:0] r_out_paw_coils;
    logic [PAW_MOTORS-1:0]   r_out_paw_en;
    logic [PAW_MOTORS:0]     r_out_moving;
    logic                    r_out_rejected;

    // motor state
    logic                            r_key_released, n_key_released;
    logic                            r_run, n_run;
    logic                            r_half_tick, n_half_tick;
    logic [2:0]                      r_top_phase, n_top_phase;
    logic signed [POSITION_BITS-1:0] r_top_pos, n_top_pos;
    logic signed [POSITION_BITS-1:0] r_top_tgt, n_top_tgt;
    logic [3:0]                      r_top_coil, n_top_coil;
    logic [2*PAW_MOTORS-1:0]         r_paw_coil, n_paw_coil;
    logic [PAW_MOTORS-1:0]           r_paw_en, n_paw_en;

    logic w_out_free;
    logic w_proc;
    logic w_tick, w_set_angle, w_set_paw;
    logic w_pressed;
    logic w_top_step, w_paw_step;
    logic w_rejected;
    logic w_angle_ok;
    logic signed [POSITION_BITS-1:0] w_angle_tgt;
    logic signed [POSITION_BITS-1:0] w_paw_val;
    logic                            w_paw_load_ok;

    logic [2*PAW_MOTORS-1:0] w_lane_coils;
    logic [PAW_MOTORS-1:0]   w_lane_en;
    logic [PAW_MOTORS-1:0]   w_lane_moving;

    // ---------------- handshakes ----------------
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_proc       = r_in_valid && w_out_free;
    assign i_item.ready = !r_in_valid || w_out_free;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_position   <= '0;
            r_down_position <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_UP_POSITION:   r_up_position   <= i_cfg.data;
                CFG_DOWN_POSITION: r_down_position <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_kind   <= i_item.kind;
            r_in_key    <= i_item.key_level;
            r_in_angle  <= i_item.angle;
            r_in_motor  <= i_item.motor_index;
            r_in_action <= i_item.paw_action;
        end
    end

    // ---------------- item decode ----------------
    always_comb begin
        w_tick      = 1'b0;
        w_set_angle = 1'b0;
        w_set_paw   = 1'b0;
        case (r_in_kind)
            KIND_TICK:  w_tick      = w_proc;
            KIND_ANGLE: w_set_angle = w_proc;
            KIND_PAW:   w_set_paw   = w_proc;
            default: ;
        endcase
    end

    msps_angle_scale #(
        .POSITION_BITS (POSITION_BITS)
    ) u_angle (
        .i_angle    (r_in_angle),
        .o_in_range (w_angle_ok),
        .o_target   (w_angle_tgt)
    );

    assign w_rejected = w_set_angle && !w_angle_ok;

    // key press is a falling edge of the key level
    assign w_pressed  = r_key_released && !r_in_key;
    assign w_top_step = w_tick && n_run;
    assign w_paw_step = w_top_step && r_half_tick;

    always_comb begin
        n_key_released = r_key_released;
        n_run          = r_run;
        n_half_tick    = r_half_tick;
        if (w_tick) begin
            n_key_released = r_in_key;
            n_run          = r_run ^ w_pressed;
        end
        if (w_top_step) begin
            n_half_tick = !r_half_tick;
        end
    end

    // ---------------- top motor ----------------
    always_comb begin
        n_top_pos   = r_top_pos;
        n_top_phase = r_top_phase;
        n_top_coil  = r_top_coil;
        n_top_tgt   = r_top_tgt;
        if (w_tick && !n_run) begin
            n_top_coil = '0;
        end else if (w_top_step && (r_top_pos != r_top_tgt)) begin
            if (r_top_tgt > r_top_pos) begin
                n_top_pos   = r_top_pos + 1'b1;
                n_top_phase = r_top_phase + 3'd1;
            end else begin
                n_top_pos   = r_top_pos - 1'b1;
                n_top_phase = r_top_phase - 3'd1;
            end
            n_top_coil = top_coil_lut(n_top_phase);
        end
        if (w_set_angle && w_angle_ok) begin
            n_top_tgt = w_angle_tgt;
        end
    end

    // ---------------- paw motors ----------------
    always_comb begin
        w_paw_val     = POSITION_BITS'(r_up_position);
        w_paw_load_ok = 1'b0;
        case (r_in_action)
            ACT_UP: begin
                w_paw_val     = POSITION_BITS'(r_up_position);
                w_paw_load_ok = 1'b1;
            end
            ACT_DOWN: begin
                w_paw_val     = POSITION_BITS'(r_down_position);
                w_paw_load_ok = 1'b1;
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < PAW_MOTORS; g++) begin : g_lane
        t_lane_ctl w_ctl;

        assign w_ctl.step = w_paw_step;
        assign w_ctl.load = w_set_paw && w_paw_load_ok
                            && ({1'b0, r_in_motor} == 4'(g + 1));

        msps_paw_lane #(
            .POSITION_BITS (POSITION_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load_val (w_paw_val),
            .o_coils    (w_lane_coils[2*g +: 2]),
            .o_enable   (w_lane_en[g]),
            .o_moving   (w_lane_moving[g])
        );
    end

    always_comb begin
        n_paw_coil = r_paw_coil;
        n_paw_en   = r_paw_en;
        if (w_tick && !n_run) begin
            n_paw_en = '0;
        end else if (w_paw_step) begin
            n_paw_coil = w_lane_coils;
            n_paw_en   = w_lane_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_released <= 1'b1;
            r_run          <= 1'b0;
            r_half_tick    <= 1'b0;
            r_top_phase    <= '0;
            r_top_pos      <= '0;
            r_top_tgt      <= '0;
            r_top_coil     <= '0;
            r_paw_coil     <= '0;
            r_paw_en       <= '0;
        end else begin
            r_key_released <= n_key_released;
            r_run          <= n_run;
            r_half_tick    <= n_half_tick;
            r_top_phase    <= n_top_phase;
            r_top_pos      <= n_top_pos;
            r_top_tgt      <= n_top_tgt;
            r_top_coil     <= n_top_coil;
            r_paw_coil     <= n_paw_coil;
            r_paw_en       <= n_paw_en;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_top_coils <= n_top_coil;
            r_out_paw_coils <= n_paw_coil;
            r_out_paw_en    <= n_paw_en;
            r_out_moving    <= {w_lane_moving, (n_top_pos != n_top_tgt)};
            r_out_rejected  <= w_rejected;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.top_coils      = r_out_top_coils;
    assign o_result.paw_coils      = r_out_paw_coils;
    assign o_result.paw_enables    = r_out_paw_en;
    assign o_result.moving         = r_out_moving;
    assign o_result.angle_rejected = r_out_rejected;

    // ---------------- assertions ----------------
    `MSPS_ASSERT_IMP(a_stopped_quiet, i_clk, i_rst_n, !r_run,
        (r_paw_en == '0) && (r_top_coil == '0), "stopped with drive active")
    `MSPS_ASSERT_NXT(a_half_tick_hold, i_clk, i_rst_n, !w_top_step,
        $stable(r_half_tick), "half tick moved without a running tick")
    `MSPS_ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_in_valid), "result without a held item")

endmodule

// ===== design/msps_angle_scale.sv =====
// ---------------------------------------------------------------------------
// msps_angle_scale
// Range check and degrees-to-steps scaling of a top motor angle.
// ---------------------------------------------------------------------------
module msps_angle_scale
    import msps_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic signed [VALUE_BITS-1:0]    i_angle,
    output logic                            o_in_range,
    output logic signed [POSITION_BITS-1:0] o_target
);

    logic                         w_neg;
    logic [7:0]                   w_mag;
    logic [PROD_BITS-1:0]         w_prod;
    logic [PROD_BITS-1:0]         w_sum;
    logic [STEPS_BITS-1:0]        w_steps;
    logic signed [STEPS_BITS:0]   w_signed;

    assign o_in_range = (i_angle <= ANGLE_LIMIT) && (i_angle >= -ANGLE_LIMIT);
    assign w_neg      = i_angle[VALUE_BITS-1];
    assign w_mag      = w_neg ? 8'(-i_angle) : 8'(i_angle);
    assign w_prod     = PROD_BITS'(w_mag) * PROD_BITS'(SCALE_MUL);
    // negative angles truncate toward zero: scale |a| with the offset reversed
    assign w_sum      = w_neg ? (w_prod - PROD_BITS'(SCALE_OFS))
                              : (w_prod + PROD_BITS'(SCALE_OFS));
    assign w_steps    = w_sum[SCALE_SHIFT +: STEPS_BITS];
    assign w_signed   = w_neg ? -$signed({1'b0, w_steps}) : $signed({1'b0, w_steps});
    assign o_target   = POSITION_BITS'(w_signed);

endmodule

// ===== design/msps_paw_lane.sv =====
// ---------------------------------------------------------------------------
// msps_paw_lane
// Position, target and phase of one 2-coil paw motor.
// ---------------------------------------------------------------------------
module msps_paw_lane
    import msps_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_lane_ctl                       i_ctl,
    input  logic signed [POSITION_BITS-1:0] i_load_val,
    output logic [1:0]                      o_coils,
    output logic                            o_enable,
    output logic                            o_moving
);

    logic signed [POSITION_BITS-1:0] r_pos, n_pos;
    logic signed [POSITION_BITS-1:0] r_tgt, n_tgt;
    logic [1:0]                      r_phase, n_phase;
    logic                            w_differs;

    assign w_differs = (r_pos != r_tgt);

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        if (i_ctl.step && w_differs) begin
            if (r_tgt > r_pos) begin
                n_pos   = r_pos + 1'b1;
                n_phase = r_phase + 2'd1;
            end else begin
                n_pos   = r_pos - 1'b1;
                n_phase = r_phase - 2'd1;
            end
        end
        n_tgt = i_ctl.load ? i_load_val : r_tgt;
    end

    assign o_coils  = paw_coil_lut(n_phase);
    assign o_enable = (n_pos != r_tgt);
    assign o_moving = (n_pos != n_tgt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_tgt   <= '0;
            r_phase <= '0;
        end else begin
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== bench/multi_stepper_position_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_stepper_position_sequencer_tb
// Drives ticks, angle commands and paw commands with random gaps and result
// backpressure, runs them through a cycle-free model of the six motors and
// compares every result item field by field, in order.
// ---------------------------------------------------------------------------
module multi_stepper_position_sequencer_tb;
    import msps_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int PAWS        = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam logic [1:0] ACT_HOLD      = 2'd2;
    localparam logic [1:0] ACT_RESERVED  = 2'd3;

    // coil patterns, entry 0 in the low bits
    localparam logic [31:0] TOP_SEQ = {4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};
    localparam logic [7:0]  PAW_SEQ = {2'h1, 2'h0, 2'h2, 2'h3};

    typedef struct packed {
        logic [1:0]         kind;
        logic               key_level;
        logic signed [15:0] angle;
        logic [2:0]         motor_index;
        logic [1:0]         paw_action;
    } t_motor_cmd;

    typedef struct packed {
        logic [3:0] top_coils;
        logic [9:0] paw_coils;
        logic [4:0] paw_enables;
        logic [5:0] moving;
        logic       angle_rejected;
    } t_motor_outputs;

    logic i_clk = 1'b0;
    logic i_rst_n;

    msps_item_if                         item_if ();
    msps_result_if #(.PAW_MOTORS(PAWS))  res_if ();
    msps_cfg_if                          cfg_if ();

    multi_stepper_position_sequencer #(
        .PAW_MOTORS    (PAWS),
        .POSITION_BITS (16)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // model state
    logic               key_up;
    logic               running;
    logic               half_tick;
    logic [2:0]         top_phase;
    logic signed [15:0] top_pos;
    logic signed [15:0] top_tgt;
    logic [1:0]         paw_phase [PAWS];
    logic signed [15:0] paw_pos [PAWS];
    logic signed [15:0] paw_tgt [PAWS];
    logic [3:0]         top_coils_q;
    logic [9:0]         paw_coils_q;
    logic [4:0]         paw_en_q;
    logic signed [15:0] up_pos;
    logic signed [15:0] down_pos;

    t_motor_outputs pending_outputs[$];
    t_motor_outputs want;
    int n_fail        = 0;
    int results_taken = 0;
    int cycles        = 0;
    logic tx_steady   = 1'b0;

    function automatic void reset_motor_model();
        key_up      = 1'b1;
        running     = 1'b0;
        half_tick   = 1'b0;
        top_phase   = '0;
        top_pos     = '0;
        top_tgt     = '0;
        top_coils_q = '0;
        paw_coils_q = '0;
        paw_en_q    = '0;
        up_pos      = '0;
        down_pos    = '0;
        for (int k = 0; k < PAWS; k++) begin
            paw_phase[k] = '0;
            paw_pos[k]   = '0;
            paw_tgt[k]   = '0;
        end
    endfunction

    // advance the model by one accepted item and queue the result it yields
    function automatic void predict_motor_outputs(input t_motor_cmd c);
        t_motor_outputs r;
        logic pressed;
        int a;
        r = '0;
        pressed = 1'b0;
        case (c.kind)
            KIND_TICK: begin
                if (key_up && !c.key_level) begin
                    key_up  = 1'b0;
                    pressed = 1'b1;
                end else if (c.key_level) begin
                    key_up = 1'b1;
                end
                if (pressed)
                    running = !running;
                if (!running) begin
                    paw_en_q    = '0;
                    top_coils_q = '0;
                end else begin
                    if (top_pos != top_tgt) begin
                        if (top_tgt > top_pos) begin
                            top_pos   = top_pos + 16'sd1;
                            top_phase = top_phase + 3'd1;
                        end else begin
                            top_pos   = top_pos - 16'sd1;
                            top_phase = top_phase - 3'd1;
                        end
                        top_coils_q = TOP_SEQ[{top_phase, 2'b00} +: 4];
                    end
                    if (!half_tick) begin
                        half_tick = 1'b1;
                    end else begin
                        half_tick = 1'b0;
                        for (int k = 0; k < PAWS; k++) begin
                            if (paw_pos[k] != paw_tgt[k]) begin
                                if (paw_tgt[k] > paw_pos[k]) begin
                                    paw_pos[k]   = paw_pos[k] + 16'sd1;
                                    paw_phase[k] = paw_phase[k] + 2'd1;
                                end else begin
                                    paw_pos[k]   = paw_pos[k] - 16'sd1;
                                    paw_phase[k] = paw_phase[k] - 2'd1;
                                end
                            end
                            paw_coils_q[2*k +: 2] = PAW_SEQ[{paw_phase[k], 1'b0} +: 2];
                            paw_en_q[k] = (paw_pos[k] != paw_tgt[k]);
                        end
                    end
                end
            end
            KIND_ANGLE: begin
                a = $signed(c.angle);
                if (a > 180 || a < -180)
                    r.angle_rejected = 1'b1;
                else
                    top_tgt = 16'((1138 * a + 50) / 100);
            end
            KIND_PAW: begin
                if (c.motor_index >= 3'd1 && c.motor_index <= 3'(PAWS)) begin
                    if (c.paw_action == ACT_UP)
                        paw_tgt[c.motor_index - 3'd1] = up_pos;
                    else if (c.paw_action == ACT_DOWN)
                        paw_tgt[c.motor_index - 3'd1] = down_pos;
                end
            end
            default: ;
        endcase
        r.moving[0] = (top_pos != top_tgt);
        for (int k = 0; k < PAWS; k++)
            r.moving[k+1] = (paw_pos[k] != paw_tgt[k]);
        r.top_coils   = top_coils_q;
        r.paw_coils   = paw_coils_q;
        r.paw_enables = paw_en_q;
        pending_outputs.push_back(r);
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_taken++;
            if (pending_outputs.size() == 0) begin
                $error("result item with nothing pending");
                n_fail++;
            end else begin
                want = pending_outputs.pop_front();
                check_field("top_coils", want.top_coils, res_if.top_coils);
                check_field("paw_coils", want.paw_coils, res_if.paw_coils);
                check_field("paw_enables", want.paw_enables, res_if.paw_enables);
                check_field("moving", want.moving, res_if.moving);
                check_field("angle_rejected", want.angle_rejected, res_if.angle_rejected);
            end
        end
    end

    // result backpressure: a fresh hold per taken item, with no-stall stretches
    initial begin
        int hold;
        int seen;
        logic rx_steady;
        hold      = 0;
        seen      = 0;
        rx_steady = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (results_taken != seen) begin
                seen = results_taken;
                if ($urandom_range(0, 39) == 0)
                    rx_steady = !rx_steady;
                hold = rx_steady ? 0 : $urandom_range(0, 19);
            end
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                hold--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input t_motor_cmd c);
        int gap;
        if ($urandom_range(0, 29) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.kind        <= c.kind;
        item_if.key_level   <= c.key_level;
        item_if.angle       <= c.angle;
        item_if.motor_index <= c.motor_index;
        item_if.paw_action  <= c.paw_action;
        item_if.valid       <= 1'b1;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
        predict_motor_outputs(c);
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic key,
                               input logic signed [15:0] angle,
                               input logic [2:0] idx, input logic [1:0] act);
        t_motor_cmd c;
        c.kind        = kind;
        c.key_level   = key;
        c.angle       = angle;
        c.motor_index = idx;
        c.paw_action  = act;
        send_item(c);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic signed [15:0] val);
        @(negedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == CFG_UP_POSITION)
            up_pos = val;
        else if (idx == CFG_DOWN_POSITION)
            down_pos = val;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic t_motor_cmd random_cmd();
        t_motor_cmd c;
        int sel;
        int v;
        // unused fields carry random noise
        c.key_level   = ($urandom_range(0, 29) != 0);
        c.angle       = 16'($urandom);
        c.motor_index = 3'($urandom);
        c.paw_action  = 2'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 62) begin
            c.kind = KIND_TICK;
        end else if (sel < 72) begin
            c.kind = KIND_ANGLE;
            case ($urandom_range(0, 9))
                7: v = $urandom_range(0, 360) - 180;
                8: v = $signed(c.angle);
                9: v = ($urandom_range(0, 1) != 0) ? 180 : -180;
                default: v = $urandom_range(0, 12) - 6;
            endcase
            c.angle = v[15:0];
        end else if (sel < 95) begin
            c.kind = KIND_PAW;
            if ($urandom_range(0, 9) != 0)
                c.motor_index = 3'($urandom_range(1, PAWS));
            if ($urandom_range(0, 9) < 8)
                c.paw_action = ($urandom_range(0, 1) != 0) ? ACT_UP : ACT_DOWN;
        end else begin
            c.kind = KIND_RESERVED;
        end
        return c;
    endfunction

    task automatic run_random_items(input int n);
        t_motor_cmd c;
        int taken;
        taken = 0;
        while (taken < n) begin
            c = random_cmd();
            send_item(c);
            if (!(c.kind == KIND_RESERVED ||
                  (c.kind == KIND_PAW && (c.motor_index == 3'd0 ||
                                          c.motor_index > 3'(PAWS)))))
                taken++;
        end
    endtask

    task automatic test_directed_edges();
        write_reg(CFG_UP_POSITION, 16'sd3);
        write_reg(CFG_DOWN_POSITION, -16'sd2);
        send_fields(KIND_RESERVED, 1'b1, 16'h7fff, 3'd7, ACT_RESERVED);
        send_fields(KIND_ANGLE, 1'b0, 16'sd180, 3'd0, ACT_UP);
        send_fields(KIND_ANGLE, 1'b0, -16'sd180, 3'd0, ACT_UP);
        send_fields(KIND_ANGLE, 1'b0, 16'sd181, 3'd0, ACT_UP);
        send_fields(KIND_ANGLE, 1'b0, -16'sd181, 3'd0, ACT_UP);
        send_fields(KIND_ANGLE, 1'b0, 16'h7fff, 3'd0, ACT_UP);
        send_fields(KIND_ANGLE, 1'b0, 16'h8000, 3'd0, ACT_UP);
        send_fields(KIND_ANGLE, 1'b0, -16'sd1, 3'd0, ACT_UP);
        send_fields(KIND_PAW, 1'b0, 16'sd0, 3'd0, ACT_UP);
        send_fields(KIND_PAW, 1'b1, 16'sd0, 3'd7, ACT_DOWN);
        send_fields(KIND_PAW, 1'b0, 16'sd0, 3'd6, ACT_UP);
        send_fields(KIND_PAW, 1'b0, 16'sd0, 3'd1, ACT_UP);
        send_fields(KIND_PAW, 1'b0, 16'sd0, 3'd5, ACT_DOWN);
        send_fields(KIND_PAW, 1'b0, 16'sd0, 3'd3, ACT_HOLD);
        send_fields(KIND_PAW, 1'b0, 16'sd0, 3'd2, ACT_RESERVED);
        // stopped tick, press to run, held key must not toggle again
        send_fields(KIND_TICK, 1'b1, 16'sd0, 3'd0, ACT_UP);
        send_fields(KIND_TICK, 1'b0, 16'sd0, 3'd0, ACT_UP);
        send_fields(KIND_TICK, 1'b0, 16'sd0, 3'd0, ACT_UP);
        repeat (3) send_fields(KIND_TICK, 1'b1, 16'sd0, 3'd0, ACT_UP);
        // press again to stop, then a stopped tick
        send_fields(KIND_TICK, 1'b0, 16'sd0, 3'd0, ACT_UP);
        send_fields(KIND_TICK, 1'b1, 16'sd0, 3'd0, ACT_UP);
        send_fields(KIND_ANGLE, 1'b1, 16'sd0, 3'd0, ACT_UP);
        wait_drained();
    endtask

    task automatic test_small_targets();
        write_reg(CFG_UP_POSITION, 16'sd5);
        write_reg(CFG_DOWN_POSITION, -16'sd4);
        send_fields(KIND_TICK, 1'b0, 16'sd0, 3'd0, ACT_UP);
        run_random_items(80);
        wait_drained();
        run_random_items(80);
        wait_drained();
    endtask

    task automatic test_extreme_targets();
        write_reg(CFG_UP_POSITION, 16'sh7fff);
        write_reg(CFG_DOWN_POSITION, 16'sh8000);
        run_random_items(100);
        wait_drained();
    endtask

    task automatic test_return_home();
        write_reg(CFG_UP_POSITION, 16'sd0);
        write_reg(CFG_DOWN_POSITION, 16'sd0);
        run_random_items(120);
        wait_drained();
    endtask

    task automatic test_random_targets();
        repeat (3) begin
            write_reg(CFG_UP_POSITION, 16'($urandom_range(0, 16) - 8));
            write_reg(CFG_DOWN_POSITION, 16'($urandom_range(0, 16) - 8));
            run_random_items(50);
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n                = 1'b0;
        item_if.valid          = 1'b0;
        item_if.kind           = KIND_TICK;
        item_if.key_level      = 1'b1;
        item_if.angle          = '0;
        item_if.motor_index    = '0;
        item_if.paw_action     = ACT_UP;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = CFG_UP_POSITION;
        cfg_if.data            = '0;
        reset_motor_model();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_small_targets();
        test_extreme_targets();
        test_return_home();
        test_random_targets();

        wait_drained();
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
